/* rtl/core/status_led_pattern_driver_macros.svh */
// assertion macros for the status led pattern driver
`ifndef STATUS_LED_PATTERN_DRIVER_MACROS_SVH
`define STATUS_LED_PATTERN_DRIVER_MACROS_SVH

`ifndef SYNTH
// antecedent holds, consequent holds in the same cycle
`define SLED_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sled assertion failed");
// antecedent holds, consequent holds in the next cycle
`define SLED_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sled assertion failed");
`else
`define SLED_ASSERT_SAME(label, clk, rst, ante, cons)
`define SLED_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/core/sled_pkg.sv */
package sled_pkg;

  // item kinds
  localparam logic [2:0] KIND_TICK     = 3'd0;
  localparam logic [2:0] KIND_LINK     = 3'd1;
  localparam logic [2:0] KIND_RUN      = 3'd2;
  localparam logic [2:0] KIND_FAULT    = 3'd3;
  localparam logic [2:0] KIND_ACTIVITY = 3'd4;

  // link modes
  localparam logic [1:0] LINK_OFF        = 2'd0;
  localparam logic [1:0] LINK_CONNECTING = 2'd1;
  localparam logic [1:0] LINK_AP         = 2'd2;
  localparam logic [1:0] LINK_CONNECTED  = 2'd3;

  // fault classes
  localparam logic [2:0] FAULT_NONE     = 3'd0;
  localparam logic [2:0] FAULT_COMM     = 3'd1;
  localparam logic [2:0] FAULT_SENSOR   = 3'd2;
  localparam logic [2:0] FAULT_NETWORK  = 3'd3;
  localparam logic [2:0] FAULT_CRITICAL = 3'd4;

  // register indexes
  localparam int NUM_REGS = 8;
  localparam int REG_IDX_W = 3;
  localparam int PADDR_W = 5;
  localparam logic [REG_IDX_W-1:0] REG_SLOW_BLINK   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FAST_BLINK   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COMM_FAULT   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SENSOR_FAULT = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_NET_FAULT    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CRIT_FAULT   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_FLASH        = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_HEARTBEAT    = 3'd7;

  typedef logic [15:0] ms_t;

  // register reset values, by index
  localparam ms_t CFG_RESET [NUM_REGS] = '{
    16'd1000, 16'd200, 16'd1000, 16'd500, 16'd250, 16'd100, 16'd50, 16'd2000
  };

  // heartbeat pulse edges
  localparam ms_t HB_FIRST_END  = 16'd100;
  localparam ms_t HB_GAP_END    = 16'd200;
  localparam ms_t HB_SECOND_END = 16'd300;

  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] link_mode;
    logic       run_flag;
    logic       fault_flag;
    logic [2:0] fault_class;
  } in_item_t;

  typedef struct packed {
    logic link_led;
    logic run_led;
    logic fault_led;
    logic activity_led;
  } out_item_t;

endpackage

/* rtl/core/status_led_pattern_driver.sv */
// status led pattern driver
// input channel (in_valid, in_ready, in_data): one beat per tick of one ms or
// per state event (link mode, run, fault, activity). output channel
// (out_valid, out_ready, out_data): one beat per input beat, the four led
// levels after that item, in input order.
// throughput: one item per cycle while in_ready is high; all counter and led
// updates are a single pass of logic from the state registers into the
// result register, or into the skid register while the output is stalled.
// a two-entry output stage (result register plus skid register) lets an
// input beat be taken while a result waits; in_ready drops only when both
// hold a result, so a stalled receiver backs up after two beats.
// configuration: apb-style port, eight 16-bit registers at byte address 4*i,
// written in the access cycle, read back on prdata; pready is always high.
// write registers only while the block is idle.
// reset (rst, synchronous): registers return to their default periods, all
// leds, modes and counters clear, and both output entries are emptied.
`include "status_led_pattern_driver_macros.svh"

module status_led_pattern_driver (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  sled_pkg::in_item_t        in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output sled_pkg::out_item_t       out_data,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sled_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import sled_pkg::*;

  // configuration registers
  ms_t cfg [NUM_REGS];

  // state
  logic [1:0] link_mode_reg;
  logic       running_reg;
  logic       fault_active_reg;
  logic [2:0] fault_class_reg;
  logic       link_led_reg;
  logic       run_led_reg;
  logic       fault_led_reg;
  logic       activity_led_reg;
  ms_t        link_elapsed;
  ms_t        fault_elapsed;
  ms_t        flash_elapsed;
  ms_t        heartbeat_phase;

  logic [1:0] link_mode_next;
  logic       running_next;
  logic       fault_active_next;
  logic [2:0] fault_class_next;
  logic       link_led_next;
  logic       run_led_next;
  logic       fault_led_next;
  logic       activity_led_next;
  ms_t        link_elapsed_next;
  ms_t        fault_elapsed_next;
  ms_t        flash_elapsed_next;
  ms_t        heartbeat_phase_next;

  // output stage
  logic      skid_valid;
  out_item_t skid_data;
  out_item_t result;

  logic in_take;
  logic out_free;
  logic cfg_write;
  logic [REG_IDX_W-1:0] reg_idx;

  // tick helpers
  ms_t         link_inc;
  ms_t         fault_inc;
  ms_t         flash_inc;
  logic [16:0] phase_sum;
  ms_t         fault_period;
  ms_t         link_half;
  ms_t         fault_half;

  function automatic ms_t sat_inc(input ms_t v);
    ms_t r;
    r = (v == 16'hFFFF) ? v : v + 16'd1;
    return r;
  endfunction

  assign in_take   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = !skid_valid;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_idx   = paddr[PADDR_W-1:2];
  assign prdata    = {16'd0, cfg[reg_idx]};

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) cfg[i] <= CFG_RESET[i];
    end else if (cfg_write) begin
      cfg[reg_idx] <= pwdata[15:0];
    end
  end

  // tick arithmetic
  always_comb begin
    link_inc  = sat_inc(link_elapsed);
    fault_inc = sat_inc(fault_elapsed);
    flash_inc = sat_inc(flash_elapsed);
    phase_sum = {1'b0, heartbeat_phase} + 17'd1;
    case (fault_class_reg)
      FAULT_SENSOR:   fault_period = cfg[REG_SENSOR_FAULT];
      FAULT_NETWORK:  fault_period = cfg[REG_NET_FAULT];
      FAULT_CRITICAL: fault_period = cfg[REG_CRIT_FAULT];
      default:        fault_period = cfg[REG_COMM_FAULT];
    endcase
    link_half  = (link_mode_reg == LINK_AP) ? (cfg[REG_FAST_BLINK] >> 1)
                                            : (cfg[REG_SLOW_BLINK] >> 1);
    fault_half = fault_period >> 1;
  end

  // next state for one item
  always_comb begin
    link_mode_next       = link_mode_reg;
    running_next         = running_reg;
    fault_active_next    = fault_active_reg;
    fault_class_next     = fault_class_reg;
    link_led_next        = link_led_reg;
    run_led_next         = run_led_reg;
    fault_led_next       = fault_led_reg;
    activity_led_next    = activity_led_reg;
    link_elapsed_next    = link_elapsed;
    fault_elapsed_next   = fault_elapsed;
    flash_elapsed_next   = flash_elapsed;
    heartbeat_phase_next = heartbeat_phase;
    case (in_data.kind)
      KIND_TICK: begin
        link_elapsed_next  = link_inc;
        fault_elapsed_next = fault_inc;
        flash_elapsed_next = flash_inc;
        heartbeat_phase_next = (phase_sum >= {1'b0, cfg[REG_HEARTBEAT]}) ? 16'd0
                                                                         : phase_sum[15:0];
        // link led
        case (link_mode_reg)
          LINK_OFF: link_led_next = 1'b0;
          LINK_CONNECTING, LINK_AP: begin
            if (link_inc >= link_half) begin
              link_led_next     = !link_led_reg;
              link_elapsed_next = 16'd0;
            end
          end
          default: link_led_next = 1'b1;
        endcase
        // heartbeat from the new phase
        run_led_next = running_reg &&
                       ((heartbeat_phase_next < HB_FIRST_END) ||
                        (heartbeat_phase_next >= HB_GAP_END &&
                         heartbeat_phase_next < HB_SECOND_END));
        // fault blink
        if (fault_active_reg && fault_inc >= fault_half) begin
          fault_led_next     = !fault_led_reg;
          fault_elapsed_next = 16'd0;
        end
        // activity flash timeout
        if (activity_led_reg && flash_inc >= cfg[REG_FLASH]) activity_led_next = 1'b0;
      end
      KIND_LINK: link_mode_next = in_data.link_mode;
      KIND_RUN:  running_next   = in_data.run_flag;
      KIND_FAULT: begin
        fault_active_next = in_data.fault_flag;
        fault_class_next  = in_data.fault_class;
        if (!in_data.fault_flag) fault_led_next = 1'b0;
      end
      KIND_ACTIVITY: begin
        flash_elapsed_next = 16'd0;
        activity_led_next  = 1'b1;
      end
      default: ;
    endcase
    result.link_led     = link_led_next;
    result.run_led      = run_led_next;
    result.fault_led    = fault_led_next;
    result.activity_led = activity_led_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      link_mode_reg    <= LINK_OFF;
      running_reg      <= 1'b0;
      fault_active_reg <= 1'b0;
      fault_class_reg  <= FAULT_NONE;
      link_led_reg     <= 1'b0;
      run_led_reg      <= 1'b0;
      fault_led_reg    <= 1'b0;
      activity_led_reg <= 1'b0;
      link_elapsed     <= 16'd0;
      fault_elapsed    <= 16'd0;
      flash_elapsed    <= 16'd0;
      heartbeat_phase  <= 16'd0;
    end else if (in_take) begin
      link_mode_reg    <= link_mode_next;
      running_reg      <= running_next;
      fault_active_reg <= fault_active_next;
      fault_class_reg  <= fault_class_next;
      link_led_reg     <= link_led_next;
      run_led_reg      <= run_led_next;
      fault_led_reg    <= fault_led_next;
      activity_led_reg <= activity_led_next;
      link_elapsed     <= link_elapsed_next;
      fault_elapsed    <= fault_elapsed_next;
      flash_elapsed    <= flash_elapsed_next;
      heartbeat_phase  <= heartbeat_phase_next;
    end
  end

  // output register and skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_take;
        if (in_take) out_data <= result;
      end
    end else if (in_take) begin
      skid_valid <= 1'b1;
      skid_data  <= result;
    end
  end

  // checks
  `SLED_ASSERT_SAME(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `SLED_ASSERT_NEXT(a_stall_fills_skid, clk, rst, in_take && !out_free, skid_valid)
  `SLED_ASSERT_NEXT(a_activity_lights, clk, rst, in_take && in_data.kind == KIND_ACTIVITY,
                    activity_led_reg && flash_elapsed == 16'd0)
  `SLED_ASSERT_NEXT(a_fault_clear_off, clk, rst,
                    in_take && in_data.kind == KIND_FAULT && !in_data.fault_flag,
                    !fault_led_reg && !fault_active_reg)

endmodule

/* tb/tb_status_led_pattern_driver.sv */
`timescale 1ns / 100ps

module tb_status_led_pattern_driver;
  import sled_pkg::*;

  // codes with no name in the package
  localparam logic [2:0] KIND_SPARE_LAST = 3'd7;
  localparam logic [2:0] FAULT_SPARE     = 3'd7;

  typedef enum {SET_RESET, SET_SHORT, SET_EXTREME} setting_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  status_led_pattern_driver dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state: register copies, modes, led levels, ms counters
  ms_t        cfg_ms [NUM_REGS];
  logic [1:0] link_mode_m;
  logic       running_m;
  logic       fault_on_m;
  logic [2:0] fault_cls_m;
  out_item_t  leds_m;
  ms_t        link_ms;
  ms_t        fault_ms;
  ms_t        flash_ms;
  ms_t        phase_m;

  out_item_t  levels_due [$];
  string      led_name [4] = '{"activity_led", "fault_led", "run_led", "link_led"};
  bit         gaps_on = 1'b1;
  int         mismatches = 0;
  int         items_sent = 0;
  int         results_seen = 0;
  int         regs_written = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic ms_t bump(input ms_t v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic half_gone(input ms_t elapsed, input ms_t period);
    return elapsed >= (period >> 1);
  endfunction

  // led levels after one item, updating the predictor state
  function automatic out_item_t predict_led_levels(input in_item_t it);
    logic [16:0] phase_next;
    ms_t         blink_ms;
    case (it.kind)
      KIND_TICK: begin
        link_ms  = bump(link_ms);
        fault_ms = bump(fault_ms);
        flash_ms = bump(flash_ms);
        phase_next = {1'b0, phase_m} + 17'd1;
        phase_m = (phase_next >= {1'b0, cfg_ms[REG_HEARTBEAT]}) ? '0 : phase_next[15:0];
        // link: fixed level or blink at the period of the mode
        if (link_mode_m == LINK_OFF) begin
          leds_m.link_led = 1'b0;
        end else if (link_mode_m == LINK_CONNECTED) begin
          leds_m.link_led = 1'b1;
        end else begin
          blink_ms = (link_mode_m == LINK_CONNECTING) ? cfg_ms[REG_SLOW_BLINK]
                                                      : cfg_ms[REG_FAST_BLINK];
          if (half_gone(link_ms, blink_ms)) begin
            leds_m.link_led = ~leds_m.link_led;
            link_ms = '0;
          end
        end
        // double-pulse heartbeat
        leds_m.run_led = running_m && (phase_m < HB_FIRST_END ||
                         (phase_m >= HB_GAP_END && phase_m < HB_SECOND_END));
        // fault blink, period by class, spare classes fall back to comm
        if (fault_on_m) begin
          case (fault_cls_m)
            FAULT_SENSOR:   blink_ms = cfg_ms[REG_SENSOR_FAULT];
            FAULT_NETWORK:  blink_ms = cfg_ms[REG_NET_FAULT];
            FAULT_CRITICAL: blink_ms = cfg_ms[REG_CRIT_FAULT];
            default:        blink_ms = cfg_ms[REG_COMM_FAULT];
          endcase
          if (half_gone(fault_ms, blink_ms)) begin
            leds_m.fault_led = ~leds_m.fault_led;
            fault_ms = '0;
          end
        end
        if (leds_m.activity_led && flash_ms >= cfg_ms[REG_FLASH])
          leds_m.activity_led = 1'b0;
      end
      KIND_LINK: link_mode_m = it.link_mode;
      KIND_RUN:  running_m = it.run_flag;
      KIND_FAULT: begin
        fault_on_m  = it.fault_flag;
        fault_cls_m = it.fault_class;
        if (!it.fault_flag)
          leds_m.fault_led = 1'b0;
      end
      KIND_ACTIVITY: begin
        flash_ms = '0;
        leds_m.activity_led = 1'b1;
      end
      default: ;
    endcase
    return leds_m;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch at %0t ns: %s", $time, what);
  endtask

  // result beats against the oldest expected levels
  always @(posedge clk) begin : check_beat
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (levels_due.size() == 0) begin
        report_mismatch($sformatf("result %b with nothing expected", out_data));
      end else begin
        want = levels_due.pop_front();
        results_seen++;
        for (int b = 3; b >= 0; b--)
          if (out_data[b] !== want[b])
            report_mismatch($sformatf("%s got %b want %b", led_name[b], out_data[b], want[b]));
      end
    end
  end

  // receiver with random stall bursts
  initial begin : result_sink
    int hold;
    hold = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold == 0 && gaps_on && $urandom_range(0, 5) == 0)
        hold = $urandom_range(1, 6);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // one input beat, then maybe a gap
  task automatic push_beat(input in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    levels_due.push_back(predict_led_levels(it));
    items_sent++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_event(input logic [2:0] kind, input logic [1:0] mode, input logic run,
                            input logic flt, input logic [2:0] cls);
    in_item_t it;
    it.kind        = kind;
    it.link_mode   = mode;
    it.run_flag    = run;
    it.fault_flag  = flt;
    it.fault_class = cls;
    push_beat(it);
  endtask

  // ticks carry junk in the fields they ignore
  task automatic send_ticks(input int n);
    in_item_t    it;
    int unsigned r;
    repeat (n) begin
      r = $urandom;
      it = r[$bits(in_item_t)-1:0];
      it.kind = KIND_TICK;
      push_beat(it);
    end
  endtask

  // hold the sender until every expected result is in
  task automatic await_idle();
    in_valid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // apb write: setup then access
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input ms_t value);
    await_idle();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_ms[idx] = value;
    regs_written++;
  endtask

  task automatic load_settings(input setting_t s);
    ms_t v;
    for (int i = 0; i < NUM_REGS; i++) begin
      case (s)
        SET_RESET: v = CFG_RESET[i];
        SET_SHORT: v = (i == REG_HEARTBEAT) ? 16'($urandom_range(120, 400))
                                            : 16'($urandom_range(0, 40));
        default:   v = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 2));
      endcase
      write_reg(REG_IDX_W'(i), v);
    end
  endtask

  // levels straight after reset, and the unused kinds
  task automatic test_reset_levels();
    in_item_t it;
    send_ticks(1);
    for (int k = int'(KIND_ACTIVITY) + 1; k <= int'(KIND_SPARE_LAST); k++) begin
      it = '1;
      it.kind = 3'(k);
      push_beat(it);
    end
  endtask

  // every link mode, blink on every tick
  task automatic test_link_modes();
    write_reg(REG_FAST_BLINK, 16'd0);
    write_reg(REG_SLOW_BLINK, 16'd1);
    send_event(KIND_LINK, LINK_CONNECTED, 1'b1, 1'b1, FAULT_SPARE);
    send_ticks(1);
    send_event(KIND_LINK, LINK_AP, 1'b0, 1'b0, FAULT_NONE);
    send_ticks(2);
    send_event(KIND_LINK, LINK_CONNECTING, 1'b0, 1'b0, FAULT_NONE);
    send_ticks(1);
    send_event(KIND_LINK, LINK_OFF, 1'b0, 1'b0, FAULT_NONE);
    send_ticks(1);
  endtask

  // fault classes with distinct periods, clear drops the led at once
  task automatic test_fault_blink();
    write_reg(REG_COMM_FAULT, 16'd0);
    write_reg(REG_SENSOR_FAULT, 16'd6);
    write_reg(REG_NET_FAULT, 16'd4);
    write_reg(REG_CRIT_FAULT, 16'hFFFF);
    send_event(KIND_FAULT, LINK_OFF, 1'b0, 1'b1, FAULT_CRITICAL);
    send_ticks(1);
    send_event(KIND_FAULT, LINK_OFF, 1'b0, 1'b1, FAULT_SENSOR);
    send_ticks(1);
    send_event(KIND_FAULT, LINK_OFF, 1'b0, 1'b1, FAULT_SPARE);
    send_ticks(1);
    if (!leds_m.fault_led)
      send_ticks(1);
    send_event(KIND_FAULT, LINK_CONNECTED, 1'b1, 1'b0, FAULT_NETWORK);
  endtask

  // zero flash still lasts until the next tick
  task automatic test_activity_flash();
    write_reg(REG_FLASH, 16'd0);
    send_event(KIND_ACTIVITY, LINK_OFF, 1'b0, 1'b0, FAULT_NONE);
    send_ticks(1);
    write_reg(REG_FLASH, 16'd2);
    send_event(KIND_ACTIVITY, LINK_CONNECTED, 1'b1, 1'b1, FAULT_SPARE);
    send_ticks(2);
  endtask

  // degenerate heartbeat cycles hold the phase at zero
  task automatic test_heartbeat_run();
    write_reg(REG_HEARTBEAT, 16'd0);
    send_event(KIND_RUN, LINK_OFF, 1'b1, 1'b0, FAULT_NONE);
    send_ticks(2);
    write_reg(REG_HEARTBEAT, 16'd1);
    send_ticks(1);
    send_event(KIND_RUN, LINK_OFF, 1'b0, 1'b0, FAULT_NONE);
    send_ticks(1);
  endtask

  // tick-heavy mix of events under one setting, drained halfway
  task automatic test_random_traffic(input setting_t s, input int n);
    in_item_t    it;
    int unsigned r;
    int          roll;
    load_settings(s);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2)
        await_idle();
      r = $urandom;
      it = r[$bits(in_item_t)-1:0];
      roll = $urandom_range(0, 99);
      if (roll < 80)
        it.kind = KIND_TICK;
      else if (roll < 97)
        it.kind = 3'($urandom_range(int'(KIND_LINK), int'(KIND_ACTIVITY)));
      else
        it.kind = 3'($urandom_range(int'(KIND_ACTIVITY) + 1, int'(KIND_SPARE_LAST)));
      push_beat(it);
    end
  endtask

  // long quiet stretch under the widest periods, then link blink and fault switched back on
  task automatic test_long_quiet();
    write_reg(REG_SLOW_BLINK, 16'hFFFF);
    write_reg(REG_COMM_FAULT, 16'hFFFF);
    write_reg(REG_FLASH, 16'hFFFF);
    write_reg(REG_HEARTBEAT, 16'hFFFF);
    send_event(KIND_LINK, LINK_OFF, 1'b0, 1'b0, FAULT_NONE);
    send_event(KIND_FAULT, LINK_OFF, 1'b0, 1'b0, FAULT_COMM);
    send_event(KIND_RUN, LINK_OFF, 1'b1, 1'b0, FAULT_NONE);
    send_event(KIND_ACTIVITY, LINK_OFF, 1'b0, 1'b0, FAULT_NONE);
    send_ticks(100);
    send_event(KIND_LINK, LINK_CONNECTING, 1'b0, 1'b0, FAULT_NONE);
    send_event(KIND_FAULT, LINK_OFF, 1'b0, 1'b1, FAULT_COMM);
    send_ticks(2);
  endtask

  initial begin
    // known levels on every input, predictor at its reset state
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    cfg_ms = CFG_RESET;
    link_mode_m = LINK_OFF;
    running_m   = 1'b0;
    fault_on_m  = 1'b0;
    fault_cls_m = FAULT_NONE;
    leds_m      = '0;
    link_ms     = '0;
    fault_ms    = '0;
    flash_ms    = '0;
    phase_m     = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_reset_levels();
    test_link_modes();
    test_fault_blink();
    test_activity_flash();
    test_heartbeat_run();
    test_random_traffic(SET_SHORT, 300);
    test_random_traffic(SET_EXTREME, 200);
    test_random_traffic(SET_SHORT, 300);
    test_random_traffic(SET_RESET, 150);

    // closing stretch at full rate on both sides
    gaps_on = 1'b0;
    test_random_traffic(SET_SHORT, 200);
    test_long_quiet();

    await_idle();
    repeat (8) @(posedge clk);
    $display("sent %0d beats, checked %0d led results, %0d register writes", items_sent,
             results_seen, regs_written);
    $display("covered link modes, fault classes, flash, heartbeat wrap and long quiet spells");
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* status_led_pattern_driver.f */
+incdir+rtl/core
rtl/core/sled_pkg.sv
rtl/core/status_led_pattern_driver.sv
tb/tb_status_led_pattern_driver.sv
